[rtl/imu_serial_frame_parser_assert.svh]
// ----------------------------------------------------------------------------
// IMU serial frame parser assertion macros
// Shared property forms for the checker of the frame parser.
// ----------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_PARSER_ASSERT_SVH
`define IMU_SERIAL_FRAME_PARSER_ASSERT_SVH

// Property that is checked only outside reset.
`define IMU_SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that is checked in every cycle, reset included.
`define IMU_SFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/imu_sfp_pkg.sv]
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Types, register map and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

  // Frame layout.
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam int FRAME_LEN = 9;
  localparam int IDX_W = $clog2(FRAME_LEN);

  // Record size default.
  localparam int FRAMES_PER_RECORD_DEF = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_ACCEL_TYPE = 2'd0;
  localparam logic [1:0] REG_ANGLE_TYPE = 2'd1;
  localparam logic [1:0] REG_TIME_TYPE  = 2'd2;
  localparam logic [7:0] ACCEL_TYPE_RST = 8'd81;
  localparam logic [7:0] ANGLE_TYPE_RST = 8'd83;
  localparam logic [7:0] TIME_TYPE_RST  = 8'd80;

  // Field widths of a record.
  localparam int ACCEL_W = 17;
  localparam int YAW_W   = 15;
  localparam int TIME_W  = 16;
  localparam int REC_W   = 2 * ACCEL_W + YAW_W + TIME_W;
  localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

  // Scale factors of the fixed-point conversions.
  localparam logic signed [27:0] ACCEL_SCALE = 28'sd1254;
  localparam logic signed [22:0] YAW_SCALE   = 23'sd45;

  // Frame types in use.
  typedef struct packed {
    logic [7:0] accel_type;
    logic [7:0] angle_type;
    logic [7:0] time_type;
  } imu_sfp_cfg_t;

  // What a finished frame does to the record.
  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_ANGLE = 3'd1,
    KIND_TIME  = 3'd2,
    KIND_OTHER = 3'd3,
    KIND_DROP  = 3'd4
  } imu_sfp_kind_t;

  // A classified frame as passed from front to back.
  typedef struct packed {
    imu_sfp_kind_t kind;
    logic [15:0]   word_a;  // data bytes 1-2
    logic [15:0]   word_b;  // data bytes 3-4
    logic [15:0]   word_c;  // data bytes 5-6
    logic [15:0]   word_d;  // data bytes 7-8
  } imu_sfp_desc_t;

endpackage

[rtl/imu_serial_frame_parser.sv]
// A record's last checksum byte is stored in the frame queue; the record then goes to the output register.
// Throughput: one received byte per cycle; the front stalls only on a checksum byte
// while the two-entry frame queue is full, and the back waits on the output register.
// Reset (rst, synchronous) restores the type registers, returns to sync hunting and
// clears the held record, the frame count, the queue and the output valid.
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Parses sync-framed sensor bytes and emits acceleration, yaw and time records.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser #(
  parameter int FRAMES_PER_RECORD = imu_sfp_pkg::FRAMES_PER_RECORD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] rx_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [16:0] accel_x, [33:17] accel_y, [48:34] yaw_angle, [64:49] time_ms, [71:65] zero
  output logic [imu_sfp_pkg::TDATA_W-1:0]     m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imu_sfp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [imu_sfp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [imu_sfp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready
);

  imu_sfp_pkg::imu_sfp_cfg_t  cfg;
  imu_sfp_pkg::imu_sfp_desc_t push_data;
  imu_sfp_pkg::imu_sfp_desc_t head_data;
  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_valid;

  // Type registers.
  imu_sfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Byte framing and classification.
  imu_sfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // Frame queue.
  imu_sfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  // Record update and output.
  imu_sfp_back #(
    .FRAMES_PER_RECORD (FRAMES_PER_RECORD)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (head_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[rtl/imu_sfp_cfg.sv]
// ----------------------------------------------------------------------------
// IMU frame parser configuration registers
// APB register file holding the three frame type codes.
// ----------------------------------------------------------------------------
module imu_sfp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imu_sfp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [imu_sfp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [imu_sfp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  output imu_sfp_pkg::imu_sfp_cfg_t           cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_type <= imu_sfp_pkg::ACCEL_TYPE_RST;
      cfg.angle_type <= imu_sfp_pkg::ANGLE_TYPE_RST;
      cfg.time_type  <= imu_sfp_pkg::TIME_TYPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        imu_sfp_pkg::REG_ACCEL_TYPE: cfg.accel_type <= pwdata[7:0];
        imu_sfp_pkg::REG_ANGLE_TYPE: cfg.angle_type <= pwdata[7:0];
        imu_sfp_pkg::REG_TIME_TYPE:  cfg.time_type  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (reg_idx)
      imu_sfp_pkg::REG_ACCEL_TYPE: prdata = {24'd0, cfg.accel_type};
      imu_sfp_pkg::REG_ANGLE_TYPE: prdata = {24'd0, cfg.angle_type};
      imu_sfp_pkg::REG_TIME_TYPE:  prdata = {24'd0, cfg.time_type};
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/imu_sfp_front.sv]
// ----------------------------------------------------------------------------
// IMU frame parser front end
// Finds sync, collects the frame, checks the sum and classifies the frame.
// ----------------------------------------------------------------------------
module imu_sfp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  imu_sfp_pkg::imu_sfp_cfg_t  cfg,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,
  input  logic                       q_full,
  output logic                       q_push,
  output imu_sfp_pkg::imu_sfp_desc_t q_data
);

  typedef enum logic [2:0] {
    ST_HUNT  = 3'b001,
    ST_BODY  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [imu_sfp_pkg::IDX_W-1:0] byte_index;
  logic [7:0]                    running_sum;
  logic [7:0]                    frame_bytes [imu_sfp_pkg::FRAME_LEN];
  logic                          take;
  logic                          date_zero;

  // Only the checksum byte needs room in the queue.
  assign s_tready = !((state == ST_CHECK) && q_full);
  assign take     = s_tvalid & s_tready;
  assign q_push   = take && (state == ST_CHECK);

  // Sequencing through sync, body and checksum.
  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT: begin
        if (take && (s_tdata == imu_sfp_pkg::SYNC_BYTE)) state_next = ST_BODY;
      end
      ST_BODY: begin
        if (take && (byte_index == imu_sfp_pkg::IDX_W'(imu_sfp_pkg::FRAME_LEN - 1)))
          state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (take) state_next = ST_HUNT;
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HUNT;
      byte_index  <= '0;
      running_sum <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        case (state)
          ST_HUNT: begin
            byte_index  <= '0;
            running_sum <= imu_sfp_pkg::SYNC_BYTE;
          end
          ST_BODY: begin
            running_sum <= running_sum + s_tdata;
            byte_index  <= byte_index + 1'b1;
          end
          ST_CHECK: byte_index <= '0;
          default:  byte_index <= '0;
        endcase
      end
    end
  end

  // Frame byte capture.
  always_ff @(posedge clk) begin
    if (take && (state == ST_BODY)) frame_bytes[byte_index] <= s_tdata;
  end

  // Classification of the finished frame.
  assign date_zero = (frame_bytes[1] == 8'd0) && (frame_bytes[2] == 8'd0) &&
                     (frame_bytes[3] == 8'd0);

  always_comb begin
    q_data.word_a = {frame_bytes[2], frame_bytes[1]};
    q_data.word_b = {frame_bytes[4], frame_bytes[3]};
    q_data.word_c = {frame_bytes[6], frame_bytes[5]};
    q_data.word_d = {frame_bytes[8], frame_bytes[7]};
    if (s_tdata != running_sum) begin
      q_data.kind = imu_sfp_pkg::KIND_DROP;
    end else if (frame_bytes[0] == cfg.accel_type) begin
      q_data.kind = imu_sfp_pkg::KIND_ACCEL;
    end else if (frame_bytes[0] == cfg.angle_type) begin
      q_data.kind = imu_sfp_pkg::KIND_ANGLE;
    end else if (frame_bytes[0] == cfg.time_type) begin
      q_data.kind = date_zero ? imu_sfp_pkg::KIND_TIME : imu_sfp_pkg::KIND_DROP;
    end else begin
      q_data.kind = imu_sfp_pkg::KIND_OTHER;
    end
  end

endmodule

[rtl/imu_sfp_queue.sv]
// ----------------------------------------------------------------------------
// IMU frame parser frame queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module imu_sfp_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  imu_sfp_pkg::imu_sfp_desc_t push_data,
  output logic                       full,
  input  logic                       pop,
  output logic                       head_valid,
  output imu_sfp_pkg::imu_sfp_desc_t head_data
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  imu_sfp_pkg::imu_sfp_desc_t entries [Depth];
  logic [PtrW-1:0]            wr_ptr;
  logic [PtrW-1:0]            rd_ptr;
  logic [CntW-1:0]            count;
  logic                       do_push;
  logic                       do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

[rtl/imu_sfp_back.sv]
// ----------------------------------------------------------------------------
// IMU frame parser back end
// Scales frame values into the held record and emits it once FRAMES_PER_RECORD frames count.
// ----------------------------------------------------------------------------
module imu_sfp_back #(
  parameter int FRAMES_PER_RECORD = imu_sfp_pkg::FRAMES_PER_RECORD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  imu_sfp_pkg::imu_sfp_desc_t          q_data,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [imu_sfp_pkg::TDATA_W-1:0]     m_tdata
);

  localparam int CountW = $clog2(FRAMES_PER_RECORD + 1);
  localparam int AW     = imu_sfp_pkg::ACCEL_W;
  localparam int YW     = imu_sfp_pkg::YAW_W;
  localparam int TW     = imu_sfp_pkg::TIME_W;

  logic signed [AW-1:0] held_accel_x;
  logic signed [AW-1:0] held_accel_y;
  logic signed [YW-1:0] held_yaw;
  logic [TW-1:0]        held_time;
  logic [CountW-1:0]    frame_count;

  logic signed [AW-1:0] accel_x_next;
  logic signed [AW-1:0] accel_y_next;
  logic signed [YW-1:0] yaw_next;
  logic [TW-1:0]        time_next;
  logic [CountW-1:0]    frame_count_next;

  logic signed [27:0]   prod_x;
  logic signed [27:0]   prod_y;
  logic signed [22:0]   prod_yaw;
  logic                 emit;

  logic signed [AW-1:0] out_accel_x;
  logic signed [AW-1:0] out_accel_y;
  logic signed [YW-1:0] out_yaw;
  logic [TW-1:0]        out_time;

  // A frame is taken whenever the output register can hold a result.
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // Fixed-point scaling; the right shift is taken as a bit select.
  assign prod_x   = $signed(q_data.word_a) * imu_sfp_pkg::ACCEL_SCALE;
  assign prod_y   = $signed(q_data.word_b) * imu_sfp_pkg::ACCEL_SCALE;
  assign prod_yaw = $signed(q_data.word_c) * imu_sfp_pkg::YAW_SCALE;

  // Record update for the frame at the queue head.
  always_comb begin
    accel_x_next     = held_accel_x;
    accel_y_next     = held_accel_y;
    yaw_next         = held_yaw;
    time_next        = held_time;
    frame_count_next = frame_count;
    case (q_data.kind)
      imu_sfp_pkg::KIND_ACCEL: begin
        accel_x_next     = prod_x[26:10];
        accel_y_next     = prod_y[26:10];
        frame_count_next = frame_count + 1'b1;
      end
      imu_sfp_pkg::KIND_ANGLE: begin
        yaw_next         = prod_yaw[21:7];
        frame_count_next = frame_count + 1'b1;
      end
      imu_sfp_pkg::KIND_TIME: begin
        time_next        = q_data.word_d;
        frame_count_next = CountW'(1);
      end
      imu_sfp_pkg::KIND_OTHER: frame_count_next = frame_count + 1'b1;
      imu_sfp_pkg::KIND_DROP:  frame_count_next = '0;
      default:                 frame_count_next = frame_count;
    endcase
  end

  assign emit = (frame_count_next >= CountW'(FRAMES_PER_RECORD));

  // Held record and frame count.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_accel_x <= '0;
      held_accel_y <= '0;
      held_yaw     <= '0;
      held_time    <= '0;
      frame_count  <= '0;
    end else if (q_pop) begin
      if (emit) begin
        held_accel_x <= '0;
        held_accel_y <= '0;
        held_yaw     <= '0;
        held_time    <= '0;
        frame_count  <= '0;
      end else begin
        held_accel_x <= accel_x_next;
        held_accel_y <= accel_y_next;
        held_yaw     <= yaw_next;
        held_time    <= time_next;
        frame_count  <= frame_count_next;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_accel_x <= accel_x_next;
      out_accel_y <= accel_y_next;
      out_yaw     <= yaw_next;
      out_time    <= time_next;
    end
  end

  assign m_tdata = {(imu_sfp_pkg::TDATA_W - imu_sfp_pkg::REC_W)'(0),
                    out_time, out_yaw, out_accel_y, out_accel_x};

endmodule

[rtl/imu_sfp_checker.sv]
// ----------------------------------------------------------------------------
// IMU serial frame parser checker
// Port-level assertions on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_serial_frame_parser_assert.svh"

module imu_sfp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [imu_sfp_pkg::TDATA_W-1:0]     m_tdata,
  input logic                                pready
);

  // A stalled record stays put.
  `IMU_SFP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "record changed while stalled")

  // Reset empties the output register and leaves the input ready.
  `IMU_SFP_ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid, "record valid after reset")
  `IMU_SFP_ASSERT_ALWAYS(a_rst_in, rst |=> s_tready, "input not ready after reset")

  // The padding above the record is always zero, and the register port never waits.
  `IMU_SFP_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[imu_sfp_pkg::TDATA_W-1:imu_sfp_pkg::REC_W] == '0), "nonzero padding")
  `IMU_SFP_ASSERT_ALWAYS(a_pready, pready, "register port not ready")

endmodule

bind imu_serial_frame_parser imu_sfp_checker u_imu_sfp_checker (.*);
